### hdl/assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mpdr_pkg.sv
package mpdr_pkg;

	// Ring geometry
	localparam int RING_DEPTH_DEF = 32;
	localparam int GROUP_SIZE     = 16;
	localparam int ID_W           = 24;

	// Header constants
	localparam logic [7:0] MAGIC_HI     = 8'hAB;
	localparam logic [7:0] MAGIC_LO     = 8'hCD;
	localparam logic [7:0] BROADCAST_ID = 8'hFF;
	localparam logic [7:0] MIN_LENGTH   = 8'd9;
	localparam logic [7:0] HEADER_BYTES = 8'd8;
	localparam logic [7:0] MAX_PAYLOAD  = 8'd220;
	localparam logic [7:0] MAX_LENGTH   = HEADER_BYTES + MAX_PAYLOAD;

	// Opcodes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_MARK  = 1'b1;

	// Payload kinds
	localparam logic [1:0] KIND_MESSAGE = 2'd0;
	localparam logic [1:0] KIND_BEACON  = 2'd1;
	localparam logic [1:0] KIND_ACK     = 2'd2;

	// Verdict codes
	localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
	localparam logic [2:0] VERDICT_SHORT     = 3'd1;
	localparam logic [2:0] VERDICT_MAGIC     = 3'd2;
	localparam logic [2:0] VERDICT_DUPLICATE = 3'd3;
	localparam logic [2:0] VERDICT_PAYLOAD   = 3'd4;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  packet_length;
		logic [15:0] magic_word;
		logic [15:0] sequence_req;
		logic [7:0]  source_id;
		logic [7:0]  dest_id;
		logic [7:0]  ttl_in;
		logic [7:0]  hops_in;
		logic [1:0]  kind;
		logic        payload_ok;
		logic        text_empty;
		logic        group_match;
	} in_word_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic       deliver;
		logic       queue_ack;
		logic       ack_for_me;
		logic       relay;
		logic [7:0] relay_ttl;
		logic [7:0] relay_hops;
	} out_word_t;

	// Ring control from the sequencer
	typedef struct packed {
		logic            shift_en;
		logic [ID_W-1:0] shift_id;
		logic [ID_W-1:0] key;
	} ring_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_GRP,
		ST_DONE
	} state_t;

endpackage

### hdl/mesh_packet_dedup_relay_filter_unit.sv
// A result passes the registered compare in every ring cell, the registered group
// reduction and the decision step before it is offered; the block takes no new word
// until the last has left the decision step, which result_stall can hold.
// Reset: arst_n clears all ring valid bits, the node address and the handshake state
// at once; the block accepts words as soon as reset is released.
`include "assert_macros.svh"

module mesh_packet_dedup_relay_filter_unit #(
	parameter int RING_DEPTH = mpdr_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                item_valid,
	output logic                item_stall,
	input  mpdr_pkg::in_word_t  item_data,
	output logic                result_valid,
	input  logic                result_stall,
	output mpdr_pkg::out_word_t result_data
);
	import mpdr_pkg::*;

	state_t     state_q, state_nxt;
	in_word_t   item_q;
	out_word_t  res_q, res_nxt;
	logic       res_valid_q;
	logic [7:0] node_id_q;
	ring_ctrl_t ring_ctrl;
	logic       hit;
	logic       accept;
	logic       leave;
	logic       header_ok;
	logic       eligible;
	logic       addressed;
	logic       ttl_live;

	assign accept = item_valid && !item_stall;
	assign leave  = (state_q == ST_DONE) && (!res_valid_q || !result_stall);

	// Hold node address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_we) begin
			node_id_q <= cfg_wdata;
		end
	end

	// Capture accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_data;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_nxt = ST_CMP;
			ST_CMP:  state_nxt = ST_GRP;
			ST_GRP:  state_nxt = ST_DONE;
			ST_DONE: if (leave) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Header checks, address match and TTL test
	assign header_ok = (item_q.packet_length >= MIN_LENGTH) &&
		(item_q.magic_word == {MAGIC_HI, MAGIC_LO});
	assign eligible  = (item_q.opcode == OP_MARK) || header_ok;
	assign addressed = (item_q.dest_id == BROADCAST_ID) || (item_q.dest_id == node_id_q);
	assign ttl_live  = item_q.ttl_in > 8'd1;

	// Control outputs
	always_comb begin
		item_stall       = (state_q != ST_IDLE);
		ring_ctrl.key    = (item_q.opcode == OP_MARK) ? {node_id_q, item_q.sequence_req}
			: {item_q.source_id, item_q.sequence_req};
		ring_ctrl.shift_id = ring_ctrl.key;
		ring_ctrl.shift_en = leave && eligible && !hit;
	end

	mpdr_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ring_ctrl),
		.hit    (hit)
	);

	// Decide verdict and relay fields
	always_comb begin
		res_nxt = '0;
		if (item_q.opcode == OP_MARK) begin
			res_nxt.verdict = hit ? VERDICT_DUPLICATE : VERDICT_ACCEPT;
		end else if (item_q.packet_length < MIN_LENGTH) begin
			res_nxt.verdict = VERDICT_SHORT;
		end else if (item_q.magic_word != {MAGIC_HI, MAGIC_LO}) begin
			res_nxt.verdict = VERDICT_MAGIC;
		end else if (hit) begin
			res_nxt.verdict = VERDICT_DUPLICATE;
		end else if ((item_q.packet_length > MAX_LENGTH) || !item_q.payload_ok) begin
			res_nxt.verdict = VERDICT_PAYLOAD;
		end else if (item_q.kind == KIND_BEACON) begin
			res_nxt.relay = ttl_live;
		end else if (item_q.kind == KIND_ACK) begin
			res_nxt.ack_for_me = addressed;
			res_nxt.relay      = ttl_live;
		end else if (item_q.text_empty) begin
			res_nxt.verdict = VERDICT_PAYLOAD;
		end else begin
			res_nxt.deliver   = item_q.group_match && addressed;
			res_nxt.queue_ack = item_q.group_match && addressed;
			res_nxt.relay     = ttl_live && (item_q.dest_id != node_id_q);
		end
		if (res_nxt.relay) begin
			res_nxt.relay_ttl  = item_q.ttl_in - 8'd1;
			res_nxt.relay_hops = item_q.hops_in + 8'd1;
		end
	end

	// Hold result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (leave) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	`ASSERT_NEXT(a_accept_starts_cmp, accept, state_q == ST_CMP, "accept did not start compare")
	`ASSERT_CLK(a_reject_clear, !result_valid || (result_data.verdict == VERDICT_ACCEPT) || (!result_data.deliver && !result_data.queue_ack && !result_data.ack_for_me && !result_data.relay), "rejected word carries flags")
	`ASSERT_CLK(a_relay_fields, !result_valid || result_data.relay || ((result_data.relay_ttl == 8'd0) && (result_data.relay_hops == 8'd0)), "relay fields set without relay")
	`ASSERT_CLK(a_insert_in_done, !ring_ctrl.shift_en || (state_q == ST_DONE), "ring insert outside decision step")

endmodule

### hdl/mpdr_cell.sv
module mpdr_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift_en,
	input  logic [mpdr_pkg::ID_W-1:0] id_in,
	input  logic                    valid_in,
	input  logic [mpdr_pkg::ID_W-1:0] key,
	output logic [mpdr_pkg::ID_W-1:0] id_out,
	output logic                    valid_out,
	output logic                    match
);
	import mpdr_pkg::*;

	logic [ID_W-1:0] id_q;
	logic            valid_q;
	logic            match_s1;

	// Advance valid bit along the chain on insert, and register the key compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (shift_en) begin
				valid_q <= valid_in;
			end
			match_s1 <= valid_q && (id_q == key);
		end
	end

	// Advance stored id along the chain on insert
	always_ff @(posedge clk) begin
		if (shift_en) begin
			id_q <= id_in;
		end
	end

	assign id_out    = id_q;
	assign valid_out = valid_q;
	assign match     = match_s1;

endmodule

### hdl/mpdr_ring.sv
module mpdr_ring #(
	parameter int RING_DEPTH = mpdr_pkg::RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpdr_pkg::ring_ctrl_t ctrl,
	output logic                 hit
);
	import mpdr_pkg::*;

	localparam int NGROUPS = (RING_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_W   = NGROUPS * GROUP_SIZE;

	logic [ID_W-1:0]       id_chain [RING_DEPTH+1];
	logic [RING_DEPTH:0]   valid_chain;
	logic [RING_DEPTH-1:0] match_vec;
	logic [PAD_W-1:0]      match_pad;
	logic [NGROUPS-1:0]    grp_s2;

	// Newest id enters the head cell; the tail cell's entry falls off
	assign id_chain[0]    = ctrl.shift_id;
	assign valid_chain[0] = 1'b1;

	for (genvar c = 0; c < RING_DEPTH; c++) begin : g_cell
		mpdr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (ctrl.shift_en),
			.id_in     (id_chain[c]),
			.valid_in  (valid_chain[c]),
			.key       (ctrl.key),
			.id_out    (id_chain[c+1]),
			.valid_out (valid_chain[c+1]),
			.match     (match_vec[c])
		);
	end

	assign match_pad = PAD_W'(match_vec);

	// Reduce cell matches by group into registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_s2 <= '0;
		end else begin
			for (int g = 0; g < NGROUPS; g++) begin
				grp_s2[g] <= |match_pad[g*GROUP_SIZE +: GROUP_SIZE];
			end
		end
	end

	assign hit = |grp_s2;

endmodule

### tb/sv/mesh_packet_dedup_relay_filter_unit_test.sv
`timescale 1ns / 1ps

module mesh_packet_dedup_relay_filter_unit_test;
	import mpdr_pkg::*;

	localparam logic [1:0] KIND_OTHER = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_WORDS = 500;
	localparam int RECENT_DEPTH = 48;

	// Mirror of the id ring and node address, plus the decisions still owed by the block
	class dedup_ledger;
		logic [ID_W-1:0] seen_id [RING_DEPTH_DEF];
		bit seen_live [RING_DEPTH_DEF];
		int unsigned wr_slot;
		logic [7:0] node_addr;
		out_word_t due_results[$];
		int errors;

		function new();
			foreach (seen_id[i]) begin
				seen_id[i] = '0;
				seen_live[i] = 1'b0;
			end
			wr_slot = 0;
			node_addr = '0;
			errors = 0;
		endfunction

		function void set_node(logic [7:0] addr);
			node_addr = addr;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Return 1 on a hit; otherwise record the id at the write slot and advance
		function bit recall_or_record(logic [ID_W-1:0] id);
			foreach (seen_id[i])
				if (seen_live[i] && seen_id[i] == id)
					return 1'b1;
			seen_id[wr_slot] = id;
			seen_live[wr_slot] = 1'b1;
			wr_slot = (wr_slot + 1 >= RING_DEPTH_DEF) ? 0 : wr_slot + 1;
			return 1'b0;
		endfunction

		function out_word_t decide(in_word_t w);
			out_word_t r;
			bit addressed;
			r = '0;
			addressed = (w.dest_id == BROADCAST_ID) || (w.dest_id == node_addr);
			if (w.opcode == OP_MARK) begin
				r.verdict = recall_or_record({node_addr, w.sequence_req}) ?
					VERDICT_DUPLICATE : VERDICT_ACCEPT;
			end else if (w.packet_length < MIN_LENGTH) begin
				r.verdict = VERDICT_SHORT;
			end else if (w.magic_word != {MAGIC_HI, MAGIC_LO}) begin
				r.verdict = VERDICT_MAGIC;
			end else if (recall_or_record({w.source_id, w.sequence_req})) begin
				r.verdict = VERDICT_DUPLICATE;
			end else if (w.packet_length - HEADER_BYTES > MAX_PAYLOAD || !w.payload_ok) begin
				r.verdict = VERDICT_PAYLOAD;
			end else if (w.kind == KIND_BEACON) begin
				r.relay = w.ttl_in > 8'd1;
			end else if (w.kind == KIND_ACK) begin
				r.ack_for_me = addressed;
				r.relay = w.ttl_in > 8'd1;
			end else if (w.text_empty) begin
				r.verdict = VERDICT_PAYLOAD;
			end else begin
				// Message, or an unknown kind handled as one
				r.deliver = w.group_match && addressed;
				r.queue_ack = r.deliver;
				r.relay = (w.ttl_in > 8'd1) && (w.dest_id != node_addr);
			end
			if (r.relay) begin
				r.relay_ttl = w.ttl_in - 8'd1;
				r.relay_hops = w.hops_in + 8'd1;
			end
			return r;
		endfunction

		function void note_word(in_word_t w);
			due_results.insert(due_results.size(), decide(w));
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (due_results.size() == 0) begin
				$error("result word with no decision pending");
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("verdict", 8'(want.verdict), 8'(got.verdict));
			compare_field("deliver", 8'(want.deliver), 8'(got.deliver));
			compare_field("queue_ack", 8'(want.queue_ack), 8'(got.queue_ack));
			compare_field("ack_for_me", 8'(want.ack_for_me), 8'(got.ack_for_me));
			compare_field("relay", 8'(want.relay), 8'(got.relay));
			compare_field("relay_ttl", want.relay_ttl, got.relay_ttl);
			compare_field("relay_hops", want.relay_hops, got.relay_hops);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_word_t item_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_word_t result_data;

	dedup_ledger ledger = new();
	logic [7:0] node_now = '0;
	int send_gap_pct = 0;
	int recv_hold_pct = 0;
	int quiet_cycles = 0;
	logic [ID_W-1:0] recent_ids[$];

	mesh_packet_dedup_relay_filter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data(item_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	always #4 clk = ~clk;

	// Receiver: stall at random, check each accepted result word
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_hold_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			ledger.check_word(result_data);
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one word, hold it until accepted, return at the next falling edge
	task automatic send_word(in_word_t w);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item_data <= w;
		do
			@(posedge clk);
		while (item_stall);
		ledger.note_word(w);
		@(negedge clk);
	endtask

	// Hold off the sender until every pending result has come back
	task automatic drain();
		item_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_node(logic [7:0] addr);
		cfg_we <= 1'b1;
		cfg_wdata <= addr;
		node_now = addr;
		ledger.set_node(addr);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic in_word_t header(logic [7:0] len, logic [15:0] magic,
			logic [15:0] seq, logic [7:0] src, logic [7:0] dst, logic [7:0] ttl,
			logic [7:0] hops, logic [1:0] kind, logic ok, logic empty, logic grp);
		in_word_t w;
		w.opcode = OP_CHECK;
		w.packet_length = len;
		w.magic_word = magic;
		w.sequence_req = seq;
		w.source_id = src;
		w.dest_id = dst;
		w.ttl_in = ttl;
		w.hops_in = hops;
		w.kind = kind;
		w.payload_ok = ok;
		w.text_empty = empty;
		w.group_match = grp;
		return w;
	endfunction

	// Mostly well-formed headers; ids often reused from recent traffic to hit the ring
	function automatic in_word_t random_word();
		in_word_t w;
		logic [ID_W-1:0] id;
		int pick;
		pick = $urandom_range(0, 9);
		w.opcode = ($urandom_range(0, 99) < 12) ? OP_MARK : OP_CHECK;
		w.packet_length = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
			8'($urandom_range(MIN_LENGTH, MAX_LENGTH + 4));
		w.magic_word = ($urandom_range(0, 9) == 0) ? 16'($urandom) : {MAGIC_HI, MAGIC_LO};
		if (recent_ids.size() > 0 && $urandom_range(0, 99) < 40)
			id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
		else
			id = ID_W'($urandom);
		w.source_id = id[23:16];
		w.sequence_req = id[15:0];
		w.dest_id = (pick < 3) ? node_now : (pick < 5) ? BROADCAST_ID : 8'($urandom);
		w.ttl_in = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
		w.hops_in = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
		w.kind = 2'($urandom_range(0, 3));
		w.payload_ok = ($urandom_range(0, 9) != 0);
		w.text_empty = ($urandom_range(0, 6) == 0);
		w.group_match = ($urandom_range(0, 2) != 0);
		recent_ids.insert(recent_ids.size(),
			(w.opcode == OP_MARK) ? {node_now, w.sequence_req} : id);
		if (recent_ids.size() > RECENT_DEPTH)
			void'(recent_ids.pop_front());
		return w;
	endfunction

	task automatic run_directed();
		in_word_t w;
		logic [15:0] good;
		good = {MAGIC_HI, MAGIC_LO};
		// Length and magic checks, in priority order
		send_word(header(8'd0, 16'hFFFF, 16'h0000, 8'h00, 8'h00, 8'd0, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(HEADER_BYTES, good, 16'h0001, 8'h11, 8'hFF, 8'd5, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(MIN_LENGTH, good, 16'h0001, 8'h11, 8'hFF, 8'd5, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(MIN_LENGTH, good, 16'h0001, 8'h11, 8'hFF, 8'd5, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(MIN_LENGTH, 16'hABCC, 16'h0002, 8'h11, 8'hFF, 8'd5, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(8'hFF, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			KIND_OTHER, 1'b1, 1'b1, 1'b1));
		// Payload length at and over the limit; an oversize packet is still recorded
		send_word(header(MAX_LENGTH, good, 16'h0003, 8'h22, node_now, 8'd3, 8'd1,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(MAX_LENGTH + 8'd1, good, 16'h0004, 8'h22, 8'hFF, 8'd3, 8'd1,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(MIN_LENGTH, good, 16'h0004, 8'h22, 8'hFF, 8'd3, 8'd1,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(8'd40, good, 16'h0005, 8'h33, 8'hFF, 8'd9, 8'd2,
			KIND_BEACON, 1'b0, 1'b0, 1'b0));
		// Beacon TTL boundary values and hops field wrap
		send_word(header(8'd40, good, 16'h0006, 8'h33, 8'hFF, 8'd1, 8'd2,
			KIND_BEACON, 1'b1, 1'b0, 1'b0));
		send_word(header(8'd40, good, 16'h0007, 8'h33, 8'hFF, 8'd2, 8'hFF,
			KIND_BEACON, 1'b1, 1'b0, 1'b0));
		// Acks to this node, to another node and broadcast
		send_word(header(8'd20, good, 16'h0008, 8'h44, node_now, 8'd0, 8'd0,
			KIND_ACK, 1'b1, 1'b0, 1'b0));
		send_word(header(8'd20, good, 16'h0009, 8'h44, 8'h01, 8'hFF, 8'd7,
			KIND_ACK, 1'b1, 1'b0, 1'b0));
		send_word(header(8'd20, good, 16'h000A, 8'h44, 8'hFF, 8'd4, 8'd7,
			KIND_ACK, 1'b1, 1'b1, 1'b1));
		// Messages: empty text, to me, out of group, to another node
		send_word(header(8'd30, good, 16'h000B, 8'h55, 8'hFF, 8'd4, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b1, 1'b1));
		send_word(header(8'd30, good, 16'h000C, 8'h55, node_now, 8'd4, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		send_word(header(8'd30, good, 16'h000D, 8'h55, 8'hFF, 8'd4, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b0));
		send_word(header(8'd30, good, 16'h000E, 8'h55, 8'h01, 8'd4, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
		// Unknown kind behaves as a message
		send_word(header(8'd30, good, 16'h000F, 8'h66, 8'hFF, 8'd4, 8'd0,
			KIND_OTHER, 1'b1, 1'b0, 1'b1));
		send_word(header(8'd30, good, 16'h0010, 8'h66, 8'hFF, 8'd4, 8'd0,
			KIND_OTHER, 1'b1, 1'b1, 1'b1));
		// Own id: mark, mark again, then hear it echoed back
		w = header(8'hA5, 16'h5A5A, 16'h1234, 8'hC3, 8'h3C, 8'h77, 8'h88,
			KIND_ACK, 1'b0, 1'b1, 1'b0);
		w.opcode = OP_MARK;
		send_word(w);
		send_word(w);
		send_word(header(8'd30, good, 16'h1234, node_now, 8'hFF, 8'd4, 8'd0,
			KIND_MESSAGE, 1'b1, 1'b0, 1'b1));
	endtask

	initial begin
		in_word_t w;
		int phase;
		int n;
		logic [7:0] node_plan [3];
		int gap_plan [3];
		int hold_plan [3];
		node_plan = '{8'hFF, 8'h00, 8'($urandom_range(1, 254))};
		gap_plan = '{14, 64, 0};
		hold_plan = '{64, 14, 0};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		write_node(8'h3C);
		run_directed();
		for (phase = 0; phase < 3; phase++) begin
			drain();
			write_node(node_plan[phase]);
			for (n = 0; n < RANDOM_WORDS; n++) begin
				// Keep a calm stretch in every hundred words
				send_gap_pct = (n % 100 >= 80) ? 0 : gap_plan[phase];
				recv_hold_pct = (n % 100 >= 80) ? 0 : hold_plan[phase];
				if (phase == 1 && n == RANDOM_WORDS / 2)
					drain();
				w = random_word();
				send_word(w);
			end
		end
		drain();
		repeat (8) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
